@@ src/lsfs_pkg.sv @@
// lsfs_pkg: shared types, codes and constants of the led strip frame serializer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package lsfs_pkg;

    // color word width and last bit index
    localparam int          COLOR_W  = 24;
    localparam logic [4:0]  BIT_TOP  = 5'd23;

    // command codes carried in the input tuser
    localparam logic [1:0]  FUNC_FILL  = 2'd0;
    localparam logic [1:0]  FUNC_CLEAR = 2'd1;
    localparam logic [1:0]  FUNC_SHOW  = 2'd2;
    localparam logic [1:0]  FUNC_TICK  = 2'd3;

    // configuration register indexes
    localparam logic [2:0]  CFG_LED_COUNT  = 3'd0;
    localparam logic [2:0]  CFG_ONE_HIGH   = 3'd1;
    localparam logic [2:0]  CFG_ONE_LOW    = 3'd2;
    localparam logic [2:0]  CFG_ZERO_HIGH  = 3'd3;
    localparam logic [2:0]  CFG_ZERO_LOW   = 3'd4;

    // configuration reset values
    localparam logic [6:0]  RST_LED_COUNT  = 7'd64;
    localparam logic [7:0]  RST_ONE_HIGH   = 8'd16;
    localparam logic [7:0]  RST_ONE_LOW    = 8'd9;
    localparam logic [7:0]  RST_ZERO_HIGH  = 8'd8;
    localparam logic [7:0]  RST_ZERO_LOW   = 8'd17;

    typedef struct packed {
        logic [6:0] led_count;
        logic [7:0] one_high;
        logic [7:0] one_low;
        logic [7:0] zero_high;
        logic [7:0] zero_low;
    } t_cfg;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic frame_done;
        logic rejected;
    } t_result;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FILL,
        ST_LOAD,
        ST_FIN
    } t_state;

    // a phase time of zero ticks lasts one tick
    function automatic logic [7:0] at_least_one(input logic [7:0] t);
        return (t == 8'd0) ? 8'd1 : t;
    endfunction

endpackage

@@ src/lsfs_store.sv @@
// lsfs_store: frame store, one 24-bit color per led, one access a cycle
// depends on lsfs_pkg for the color width
`timescale 1ns / 1ps

module lsfs_store import lsfs_pkg::*; #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic               i_clk,
    input  t_mem_ctl           i_ctl,
    input  logic [AW-1:0]      i_addr,
    input  logic [COLOR_W-1:0] i_wdata,
    output logic [COLOR_W-1:0] o_rdata
);

    logic [COLOR_W-1:0] r_mem [DEPTH];
    logic [COLOR_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    // registered read, held until the next read
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/lsfs_ctrl.sv @@
// lsfs_ctrl: command sequencer and line waveform generator
// depends on lsfs_pkg; drives the frame store in lsfs_store
`timescale 1ns / 1ps

module lsfs_ctrl import lsfs_pkg::*; #(
    parameter int MAX_LEDS = 64,
    parameter int AW       = 6,
    parameter int CW       = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_func,
    input  logic [5:0]         i_first_led,
    input  logic [6:0]         i_fill_count,
    input  logic [COLOR_W-1:0] i_color,
    input  logic               i_out_free,
    output logic               o_res_valid,
    output t_result            o_res,
    output t_mem_ctl           o_mem,
    output logic [AW-1:0]      o_mem_addr,
    output logic [COLOR_W-1:0] o_mem_wdata,
    input  logic [COLOR_W-1:0] i_mem_rdata
);

    t_state             r_state, n_state;
    logic [CW-1:0]      r_ptr, n_ptr;
    logic [CW-1:0]      r_end, n_end;
    logic [COLOR_W-1:0] r_color, n_color;
    logic               r_clr_res, n_clr_res;
    logic               r_sending, n_sending;
    logic               r_high, n_high;
    logic [4:0]         r_bit, n_bit;
    logic [7:0]         r_ticks, n_ticks;
    logic [CW-1:0]      r_led, n_led;
    logic [COLOR_W-1:0] r_shift, n_shift;
    t_result            r_res, n_res;

    logic          w_accept;
    logic [CW-1:0] w_eff;
    logic [7:0]    w_tr;
    logic          w_expire;
    logic [CW-1:0] w_next_led;
    logic          w_last_bit;
    logic          w_frame_end;
    logic [CW-1:0] w_fill_raw;
    logic [CW-1:0] w_fill_end;
    logic          w_fill_ok;
    logic          w_rej;
    logic          w_led_adv;

    // shared decode of the request and of the tick countdown
    always_comb begin
        w_accept    = i_valid && o_ready;
        w_eff       = (CW'(i_cfg.led_count) > CW'(MAX_LEDS)) ? CW'(MAX_LEDS)
                                                             : CW'(i_cfg.led_count);
        w_tr        = (r_ticks != 8'd0) ? (r_ticks - 8'd1) : 8'd0;
        w_expire    = (w_tr == 8'd0);
        w_next_led  = r_led + CW'(1);
        w_last_bit  = (r_bit == BIT_TOP);
        w_frame_end = (w_next_led >= w_eff) || (w_next_led >= CW'(MAX_LEDS));
        w_fill_raw  = (i_fill_count == 7'd0) ? w_eff
                                             : (CW'(i_first_led) + CW'(i_fill_count));
        w_fill_end  = (w_fill_raw > w_eff) ? w_eff : w_fill_raw;
        w_fill_ok   = (CW'(i_first_led) < w_eff);
        w_rej       = (i_func != FUNC_TICK) && r_sending;
        w_led_adv   = r_sending && w_expire && !r_high && w_last_bit && !w_frame_end;
    end

    assign o_ready = (r_state == ST_IDLE) && i_out_free;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && !w_rej) begin
                    unique case (i_func)
                        FUNC_FILL:  n_state = w_fill_ok ? ST_FILL : ST_IDLE;
                        FUNC_CLEAR: n_state = ST_CLEAR;
                        FUNC_SHOW:  n_state = (w_eff != '0) ? ST_LOAD : ST_IDLE;
                        FUNC_TICK:  n_state = w_led_adv ? ST_LOAD : ST_IDLE;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_FILL:  n_state = ((r_ptr + CW'(1)) >= r_end) ? ST_FIN : ST_FILL;
            ST_CLEAR: begin
                if (r_ptr == CW'(MAX_LEDS - 1)) begin
                    n_state = r_clr_res ? ST_FIN : ST_IDLE;
                end
            end
            ST_LOAD:  n_state = ST_FIN;
            ST_FIN:   n_state = i_out_free ? ST_IDLE : ST_FIN;
            default:  n_state = ST_IDLE;
        endcase
    end

    // datapath, store access and result
    always_comb begin
        n_ptr       = r_ptr;
        n_end       = r_end;
        n_color     = r_color;
        n_clr_res   = r_clr_res;
        n_sending   = r_sending;
        n_high      = r_high;
        n_bit       = r_bit;
        n_ticks     = r_ticks;
        n_led       = r_led;
        n_shift     = r_shift;
        n_res       = r_res;
        o_mem       = '0;
        o_mem_addr  = r_ptr[AW-1:0];
        o_mem_wdata = r_color;
        o_res_valid = 1'b0;
        o_res       = r_res;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    o_res = '0;
                    if (w_rej) begin
                        o_res_valid     = 1'b1;
                        o_res.line_level = r_high;
                        o_res.busy_res  = 1'b1;
                        o_res.rejected  = 1'b1;
                    end else begin
                        unique case (i_func)
                            FUNC_FILL: begin
                                if (w_fill_ok) begin
                                    n_ptr   = CW'(i_first_led);
                                    n_end   = w_fill_end;
                                    n_color = i_color;
                                    n_res   = '0;
                                end else begin
                                    o_res_valid = 1'b1;
                                end
                            end
                            FUNC_CLEAR: begin
                                n_ptr     = '0;
                                n_color   = '0;
                                n_clr_res = 1'b1;
                                n_res     = '0;
                            end
                            FUNC_SHOW: begin
                                if (w_eff != '0) begin
                                    n_sending  = 1'b1;
                                    n_led      = '0;
                                    n_bit      = '0;
                                    o_mem.rd_en = 1'b1;
                                    o_mem_addr = '0;
                                end else begin
                                    o_res_valid = 1'b1;
                                end
                            end
                            FUNC_TICK: begin
                                o_res_valid = 1'b1;
                                if (r_sending) begin
                                    n_ticks        = w_tr;
                                    o_res.busy_res = 1'b1;
                                    o_res.line_level = r_high;
                                    if (w_expire) begin
                                        if (r_high) begin
                                            // high time over, enter low time
                                            n_high  = 1'b0;
                                            n_ticks = at_least_one(r_shift[COLOR_W-1]
                                                      ? i_cfg.one_low : i_cfg.zero_low);
                                            o_res.line_level = 1'b0;
                                        end else if (!w_last_bit) begin
                                            // next bit of the same led
                                            n_bit   = r_bit + 5'd1;
                                            n_shift = {r_shift[COLOR_W-2:0], 1'b0};
                                            n_high  = 1'b1;
                                            n_ticks = at_least_one(r_shift[COLOR_W-2]
                                                      ? i_cfg.one_high : i_cfg.zero_high);
                                            o_res.line_level = 1'b1;
                                        end else begin
                                            n_bit = '0;
                                            if (w_frame_end) begin
                                                // last led done
                                                n_sending = 1'b0;
                                                n_high    = 1'b0;
                                                n_ticks   = '0;
                                                n_shift   = '0;
                                                n_led     = '0;
                                                o_res.busy_res   = 1'b0;
                                                o_res.frame_done = 1'b1;
                                            end else begin
                                                // fetch the next led color
                                                n_led       = w_next_led;
                                                o_mem.rd_en = 1'b1;
                                                o_mem_addr  = w_next_led[AW-1:0];
                                                o_res_valid = 1'b0;
                                            end
                                        end
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            ST_FILL: begin
                o_mem.wr_en = 1'b1;
                n_ptr       = r_ptr + CW'(1);
            end
            ST_CLEAR: begin
                o_mem.wr_en = 1'b1;
                o_mem_wdata = '0;
                n_ptr       = r_ptr + CW'(1);
            end
            ST_LOAD: begin
                // start the high time of the first bit of the fetched led
                n_shift = i_mem_rdata;
                n_high  = 1'b1;
                n_ticks = at_least_one(i_mem_rdata[COLOR_W-1]
                          ? i_cfg.one_high : i_cfg.zero_high);
                n_res            = '0;
                n_res.line_level = 1'b1;
                n_res.busy_res   = 1'b1;
            end
            ST_FIN: begin
                o_res_valid = i_out_free;
                if (i_out_free) begin
                    n_clr_res = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_ptr     <= '0;
            r_clr_res <= 1'b0;
            r_sending <= 1'b0;
            r_high    <= 1'b0;
            r_bit     <= '0;
            r_ticks   <= '0;
            r_led     <= '0;
            r_shift   <= '0;
        end else begin
            r_state   <= n_state;
            r_ptr     <= n_ptr;
            r_clr_res <= n_clr_res;
            r_sending <= n_sending;
            r_high    <= n_high;
            r_bit     <= n_bit;
            r_ticks   <= n_ticks;
            r_led     <= n_led;
            r_shift   <= n_shift;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_end   <= n_end;
        r_color <= n_color;
        r_res   <= n_res;
    end

endmodule

@@ src/led_strip_frame_serializer_top.sv @@
// led strip frame serializer: tick, rejected and no-op requests reach the output
// register in the cycle after acceptance; show and a tick that moves to the next led
// read the store via load and finish states; fill writes its led range and clear all
// MAX_LEDS entries before the finish state. one request in flight at a time; the store
// port is shared by fill, clear, show and tick. synchronous active-low reset restores
// control and config registers, then clears all MAX_LEDS entries, accepting no request
`timescale 1ns / 1ps

module led_strip_frame_serializer_top import lsfs_pkg::*; #(
    parameter int MAX_LEDS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // first_led[5:0], fill_count[12:6], color[36:13]
    input  logic [1:0]  s_axis_tuser,   // func[1:0]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // line_level[0], busy_res[1]
    output logic        m_axis_tlast,   // frame_done
    output logic        m_axis_tuser,   // rejected
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    localparam int AW  = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int CWN = $clog2(MAX_LEDS + 1);
    localparam int CW  = (CWN > 8) ? CWN : 8;

    t_cfg               r_cfg;
    logic               r_m_valid;
    t_result            r_m_res;
    logic               w_out_free;
    logic               w_res_valid;
    t_result            w_res;
    t_mem_ctl           w_mem;
    logic [AW-1:0]      w_mem_addr;
    logic [COLOR_W-1:0] w_mem_wdata;
    logic [COLOR_W-1:0] w_mem_rdata;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.led_count <= RST_LED_COUNT;
            r_cfg.one_high  <= RST_ONE_HIGH;
            r_cfg.one_low   <= RST_ONE_LOW;
            r_cfg.zero_high <= RST_ZERO_HIGH;
            r_cfg.zero_low  <= RST_ZERO_LOW;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_LED_COUNT: r_cfg.led_count <= i_cfg_data[6:0];
                CFG_ONE_HIGH:  r_cfg.one_high  <= i_cfg_data;
                CFG_ONE_LOW:   r_cfg.one_low   <= i_cfg_data;
                CFG_ZERO_HIGH: r_cfg.zero_high <= i_cfg_data;
                CFG_ZERO_LOW:  r_cfg.zero_low  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // output register
    assign w_out_free = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_res_valid) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_m_res <= w_res;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {6'd0, r_m_res.busy_res, r_m_res.line_level};
    assign m_axis_tlast  = r_m_res.frame_done;
    assign m_axis_tuser  = r_m_res.rejected;

    lsfs_ctrl #(
        .MAX_LEDS (MAX_LEDS),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_func       (s_axis_tuser),
        .i_first_led  (s_axis_tdata[5:0]),
        .i_fill_count (s_axis_tdata[12:6]),
        .i_color      (s_axis_tdata[36:13]),
        .i_out_free   (w_out_free),
        .o_res_valid  (w_res_valid),
        .o_res        (w_res),
        .o_mem        (w_mem),
        .o_mem_addr   (w_mem_addr),
        .o_mem_wdata  (w_mem_wdata),
        .i_mem_rdata  (w_mem_rdata)
    );

    lsfs_store #(
        .DEPTH (MAX_LEDS),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_ctl   (w_mem),
        .i_addr  (w_mem_addr),
        .i_wdata (w_mem_wdata),
        .o_rdata (w_mem_rdata)
    );

endmodule
